/* hdl/pctd_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pctd_pkg
// Shared constants and controller/datapath interface types for the prime
// counter (trial division).
// -----------------------------------------------------------------------------
package pctd_pkg;

    // Field and parameter defaults
    localparam int LIMIT_BITS_DEF = 16;
    localparam int COUNT_W        = 13;

    // First odd candidate and first trial divisor, and the odd stride
    localparam int FIRST_ODD = 3;
    localparam int ODD_STEP  = 2;

    // Restoring remainder steps done per clock in the divider
    localparam int DIV_BITS_PER_CYCLE = 4;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // take a new limit, start at candidate 3
        logic count_inc;  // current candidate is prime
        logic next_cand;  // advance candidate, restart divisor at 3
        logic div_start;  // start remainder of candidate by divisor
        logic div_next;   // advance divisor by 2, update its square
        logic out_load;   // copy count into the output register
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic cand_gt_lim;  // candidate is past the limit
        logic sq_gt_cand;   // divisor squared exceeds candidate
        logic div_busy;     // remainder unit running
        logic rem_done;     // remainder valid
        logic rem_zero;     // remainder is zero
    } sts_t;

endpackage
`default_nettype wire

/* hdl/pctd_divider.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pctd_divider
// Multi-cycle restoring remainder unit: dividend mod divisor, several
// quotient bits resolved per clock.
// -----------------------------------------------------------------------------
module pctd_divider #(
    parameter int VW = 17,  // dividend width
    parameter int DW = 10   // divisor width
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [VW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [DW-1:0]      remainder
);
    import pctd_pkg::*;

    localparam int BPC  = DIV_BITS_PER_CYCLE;
    localparam int NCYC = (VW + BPC - 1) / BPC;
    localparam int PW   = NCYC * BPC;
    localparam int CW   = $clog2(NCYC + 1);

    logic [PW-1:0] shf_reg,  shf_next;
    logic [DW-1:0] rem_reg,  rem_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          done_reg, done_next;
    logic [DW-1:0] rem_step;

    // BPC chained restoring steps; partial remainder stays below divisor
    always_comb
    begin
        logic [DW:0] t;
        rem_step = rem_reg;
        for (int i = 0; i < BPC; i++)
        begin
            t = {rem_step, shf_reg[PW-1-i]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
            end
            rem_step = t[DW-1:0];
        end
    end

    // Sequencing
    always_comb
    begin
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            shf_next  = PW'(dividend);
            rem_next  = '0;
            cnt_next  = CW'(NCYC);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            shf_next  = shf_reg << BPC;
            rem_next  = rem_step;
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        shf_reg <= shf_next;
        rem_reg <= rem_next;
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

/* hdl/pctd_datapath.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pctd_datapath
// Limit, candidate, divisor, divisor-square, count and output registers
// plus the remainder unit. Driven by the controller's commands.
// -----------------------------------------------------------------------------
module pctd_datapath #(
    parameter int LIMIT_BITS = pctd_pkg::LIMIT_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [LIMIT_BITS-1:0]    limit,
    input  pctd_pkg::cmd_t                cmd,
    output pctd_pkg::sts_t                sts,
    output logic [pctd_pkg::COUNT_W-1:0]  prime_count
);
    import pctd_pkg::*;

    // Candidate gets one spare bit so stepping past the limit cannot wrap
    localparam int VW = LIMIT_BITS + 1;
    localparam int DW = VW / 2 + 2;
    localparam int SW = 2 * DW;
    localparam int FIRST_SQ = FIRST_ODD * FIRST_ODD;

    logic [LIMIT_BITS-1:0] lim_reg,   lim_next;
    logic [VW-1:0]         cand_reg,  cand_next;
    logic [DW-1:0]         d_reg,     d_next;
    logic [SW-1:0]         sq_reg,    sq_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    pc_reg,    pc_next;

    logic          div_busy;
    logic          div_done;
    logic [DW-1:0] div_rem;

    pctd_divider #(
        .VW (VW),
        .DW (DW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (cand_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Register updates
    always_comb
    begin
        lim_next   = lim_reg;
        cand_next  = cand_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        count_next = count_reg;
        pc_next    = pc_reg;
        if (cmd.load)
        begin
            lim_next   = limit;
            cand_next  = VW'(FIRST_ODD);
            d_next     = DW'(FIRST_ODD);
            sq_next    = SW'(FIRST_SQ);
            // 2 is counted on its own
            count_next = (limit >= LIMIT_BITS'(ODD_STEP)) ? COUNT_W'(1) : '0;
        end
        else
        begin
            if (cmd.count_inc)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            if (cmd.next_cand)
            begin
                cand_next = cand_reg + VW'(ODD_STEP);
                d_next    = DW'(FIRST_ODD);
                sq_next   = SW'(FIRST_SQ);
            end
            else if (cmd.div_next)
            begin
                // (d+2)^2 = d^2 + 4d + 4
                d_next  = d_reg + DW'(ODD_STEP);
                sq_next = sq_reg + SW'({d_reg, 2'b00}) + SW'(2 * ODD_STEP);
            end
        end
        if (cmd.out_load)
        begin
            pc_next = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        cand_reg  <= cand_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        count_reg <= count_next;
        pc_reg    <= pc_next;
    end

    // Status
    assign sts.cand_gt_lim = (cand_reg > VW'(lim_reg));
    assign sts.sq_gt_cand  = (sq_reg > SW'(cand_reg));
    assign sts.div_busy    = div_busy;
    assign sts.rem_done    = div_done;
    assign sts.rem_zero    = (div_rem == '0);

    assign prime_count = pc_reg;

endmodule
`default_nettype wire

/* hdl/pctd_ctrl.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// pctd_ctrl
// Controller: walks odd candidates and trial divisors, issues datapath
// commands and runs both handshakes.
// -----------------------------------------------------------------------------
module pctd_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  pctd_pkg::sts_t sts,
    output pctd_pkg::cmd_t cmd
);
    import pctd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TEST   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (sts.cand_gt_lim)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.sq_gt_cand)
                begin
                    // no divisor up to sqrt: prime
                    cmd.count_inc = 1'b1;
                    cmd.next_cand = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.rem_done)
                begin
                    if (sts.rem_zero)
                    begin
                        cmd.next_cand = 1'b1;
                    end
                    else
                    begin
                        cmd.div_next = 1'b1;
                    end
                    state_next = ST_TEST;
                end
            end
            ST_FINISH:
            begin
                // wait for a free output slot
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* hdl/prime_counter_trial_division.sv */
`default_nettype none
// Throughput: one item at a time; the 4-bit-per-cycle remainder unit sets it.
// A finished result waits in the output register while the next item runs.
// Reset: asynchronous, active low; returns idle with no result pending.
// -----------------------------------------------------------------------------
// prime_counter_trial_division
// Counts primes <= limit by trial division of odd candidates with odd
// divisors up to the square root.
// -----------------------------------------------------------------------------
module prime_counter_trial_division #(
    parameter int LIMIT_BITS = pctd_pkg::LIMIT_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [LIMIT_BITS-1:0]    limit,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [pctd_pkg::COUNT_W-1:0]  prime_count
);
    import pctd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pctd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pctd_datapath #(
        .LIMIT_BITS (LIMIT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (limit),
        .cmd         (cmd),
        .sts         (sts),
        .prime_count (prime_count)
    );

`ifndef SYNTH
    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // Remainder unit is never restarted while running
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while busy");

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("pending result overwritten");

    // Remainder is reported only after the unit has stopped
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.rem_done |-> !sts.div_busy)
        else $error("remainder done while busy");
`endif

endmodule
`default_nettype wire
